>>> rtl/fud_pkg.sv
package fud_pkg;

	// special characters of a form body
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_EQUALS  = 8'h3D;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [3:0] HEX_TEN    = 4'hA;

	// input operation codes
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_END  = 1'b1;

	// one decoded result
	typedef struct packed {
		logic [7:0] out_byte;
		logic       in_value;
		logic       pair_end;
	} out_item_t;

	// hex digit check and value, either case
	typedef struct packed {
		logic       ok;
		logic [3:0] nib;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] b);
		hex_t r;
		logic [7:0] d;
		r.ok  = 1'b0;
		r.nib = 4'h0;
		d     = 8'h00;
		if (b >= 8'h30 && b <= 8'h39) begin
			d     = b - 8'h30;
			r.ok  = 1'b1;
			r.nib = d[3:0];
		end else if (b >= 8'h41 && b <= 8'h46) begin
			d     = b - 8'h41;
			r.ok  = 1'b1;
			r.nib = d[3:0] + HEX_TEN;
		end else if (b >= 8'h61 && b <= 8'h66) begin
			d     = b - 8'h61;
			r.ok  = 1'b1;
			r.nib = d[3:0] + HEX_TEN;
		end
		return r;
	endfunction

endpackage

>>> rtl/fud_if.sv
// body byte channel
interface fud_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] data_byte;

	modport source (output valid, output op, output data_byte, input ready);
	modport sink   (input valid, input op, input data_byte, output ready);
endinterface

// decoded byte channel
interface fud_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       in_value;
	logic       pair_end;

	modport source (output valid, output out_byte, output in_value, output pair_end,
		input ready);
	modport sink   (input valid, input out_byte, input in_value, input pair_end,
		output ready);
endinterface

>>> rtl/form_urlencoded_decoder.sv
// channel | direction | payload                       | transfer when
// body    | in        | op, data_byte                 | valid && ready
// dec     | out       | out_byte, in_value, pair_end  | valid && ready
//
// one body item per cycle while skid is free; a decoded byte is on dec the cycle after its transfer unless dec stalls
// parse state (phase, escape, high nibble) is updated at the body transfer itself
// a two-entry output (register plus skid) lets body keep flowing while dec stalls once
// body.ready drops only while the skid entry is occupied
// arst_n clears the parse state and both output valids; payloads are not reset
module form_urlencoded_decoder (
	input logic     clk,
	input logic     arst_n,
	fud_in_if.sink  body,
	fud_out_if.source dec
);
	import fud_pkg::*;

	// escape phase codes
	localparam logic [1:0] ESC_NONE   = 2'd0;
	localparam logic [1:0] ESC_HI     = 2'd1;
	localparam logic [1:0] ESC_LO     = 2'd2;
	localparam logic [1:0] ESC_UNUSED = 2'd3;

	logic       value_q;
	logic [1:0] esc_q;
	logic [3:0] hi_q;

	logic       value_d;
	logic [1:0] esc_d;
	logic [3:0] hi_d;

	out_item_t  res;
	logic       emit;
	logic       do_plain;
	hex_t       hx;

	out_item_t  dout_q;
	logic       dvalid_q;
	out_item_t  skid_q;
	logic       skid_valid_q;

	logic       accept;
	logic       take;

	assign accept     = body.valid && body.ready;
	assign take       = dvalid_q && dec.ready;
	assign body.ready = !skid_valid_q;

	assign hx = hex_decode(body.data_byte);

	// next state and result for one body item
	always_comb begin
		value_d  = value_q;
		esc_d    = esc_q;
		hi_d     = hi_q;
		emit     = 1'b0;
		do_plain = 1'b0;
		res      = '{out_byte: body.data_byte, in_value: value_q, pair_end: 1'b0};
		if (body.op == OP_END) begin
			value_d = 1'b0;
			esc_d   = ESC_NONE;
			hi_d    = 4'h0;
			emit    = 1'b1;
			res     = '{out_byte: 8'h00, in_value: value_q, pair_end: 1'b1};
		end else begin
			unique case (esc_q)
				ESC_HI: begin
					if (hx.ok) begin
						hi_d  = hx.nib;
						esc_d = ESC_LO;
					end else begin
						esc_d    = ESC_NONE;
						do_plain = 1'b1;
					end
				end
				ESC_LO: begin
					esc_d = ESC_NONE;
					if (hx.ok) begin
						emit         = 1'b1;
						res.out_byte = {hi_q, hx.nib};
					end else begin
						do_plain = 1'b1;
					end
				end
				default: begin
					esc_d    = ESC_NONE;
					do_plain = 1'b1;
				end
			endcase
			// plain byte of the current phase
			if (do_plain) begin
				if (body.data_byte == CH_PERCENT) begin
					esc_d = ESC_HI;
				end else if (body.data_byte == CH_PLUS) begin
					emit         = 1'b1;
					res.out_byte = CH_SPACE;
				end else if (!value_q && body.data_byte == CH_EQUALS) begin
					value_d = 1'b1;
				end else if (value_q && body.data_byte == CH_AMP) begin
					value_d = 1'b0;
					emit    = 1'b1;
					res     = '{out_byte: 8'h00, in_value: 1'b1, pair_end: 1'b1};
				end else begin
					emit = 1'b1;
				end
			end
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= 1'b0;
			esc_q   <= ESC_NONE;
			hi_q    <= 4'h0;
		end else if (accept) begin
			value_q <= value_d;
			esc_q   <= esc_d;
			hi_q    <= hi_d;
		end
	end

	// output register and skid entry, valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvalid_q     <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				dvalid_q <= accept && emit;
			end
		end else if (accept && emit) begin
			if (!dvalid_q) begin
				dvalid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// output register and skid entry, payloads
	always_ff @(posedge clk) begin
		if (take) begin
			dout_q <= skid_valid_q ? skid_q : res;
		end else if (accept && emit) begin
			if (!dvalid_q) begin
				dout_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign dec.valid    = dvalid_q;
	assign dec.out_byte = dout_q.out_byte;
	assign dec.in_value = dout_q.in_value;
	assign dec.pair_end = dout_q.pair_end;

	// the skid entry only holds a result behind a waiting one
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> dvalid_q)
		else $error("skid entry occupied with empty output register");

	// the skid entry fills only when the output was stalled
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(dvalid_q && !dec.ready))
		else $error("skid entry filled while output was free");

	// the unused escape code never arises
	a_esc_code: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q != ESC_UNUSED)
		else $error("unused escape code held");

	// end of body returns the parser to the name phase with no escape
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && body.op == OP_END) |=> (!value_q && esc_q == ESC_NONE))
		else $error("end of body did not clear the parse state");

	// a pair-end result carries no byte
	a_pair_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(dec.valid && dec.pair_end) |-> dec.out_byte == 8'h00)
		else $error("pair-end result with a non-zero byte");

endmodule

>>> tb/tb_form_urlencoded_decoder.sv
`timescale 1ns / 1ps

module tb_form_urlencoded_decoder;
	import fud_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 20;

	// escape progress of the predictor
	typedef enum bit [1:0] {
		ESC_NONE   = 2'd0,
		ESC_FIRST  = 2'd1,
		ESC_SECOND = 2'd2
	} esc_state_t;

	// predicts decoded bytes and checks them in order
	class decode_board;
		bit             in_value_now;
		esc_state_t     esc;
		bit [3:0]       first_nibble;
		out_item_t      expected_decoded[$];
		int             errors;

		function void clear_parse();
			in_value_now = 1'b0;
			esc          = ESC_NONE;
			first_nibble = 4'h0;
		endfunction

		// 0..15 for a hex digit of either case, 16 otherwise
		function int nibble_of(logic [7:0] b);
			if (b >= "0" && b <= "9")
				return int'(b - "0");
			if (b >= "A" && b <= "F")
				return int'(b - "A") + 10;
			if (b >= "a" && b <= "f")
				return int'(b - "a") + 10;
			return 16;
		endfunction

		function void expect_item(logic [7:0] b, logic val, logic pend);
			out_item_t it;
			it.out_byte = b;
			it.in_value = val;
			it.pair_end = pend;
			expected_decoded.push_back(it);
		endfunction

		// a byte outside any escape
		function void plain_byte(logic [7:0] b);
			if (b == CH_PERCENT) begin
				esc = ESC_FIRST;
			end else if (b == CH_PLUS) begin
				expect_item(CH_SPACE, in_value_now, 1'b0);
			end else if (!in_value_now && b == CH_EQUALS) begin
				in_value_now = 1'b1;
			end else if (in_value_now && b == CH_AMP) begin
				in_value_now = 1'b0;
				expect_item(8'h00, 1'b1, 1'b1);
			end else begin
				expect_item(b, in_value_now, 1'b0);
			end
		endfunction

		// one accepted body transfer
		function void note_body(logic op, logic [7:0] b);
			int nib;
			logic held;
			if (op == OP_END) begin
				held = in_value_now;
				clear_parse();
				expect_item(8'h00, held, 1'b1);
				return;
			end
			nib = nibble_of(b);
			case (esc)
				ESC_FIRST: begin
					if (nib < 16) begin
						first_nibble = nib[3:0];
						esc = ESC_SECOND;
					end else begin
						esc = ESC_NONE;
						plain_byte(b);
					end
				end
				ESC_SECOND: begin
					esc = ESC_NONE;
					if (nib < 16)
						expect_item({first_nibble, nib[3:0]}, in_value_now, 1'b0);
					else
						plain_byte(b);
				end
				default: begin
					esc = ESC_NONE;
					plain_byte(b);
				end
			endcase
		endfunction

		// one accepted decoded transfer
		function void check_dec(out_item_t got);
			out_item_t want;
			if (expected_decoded.size() == 0) begin
				errors++;
				$display("%0t: unexpected result byte=%02h in_value=%0b pair_end=%0b",
					$time, got.out_byte, got.in_value, got.pair_end);
				return;
			end
			want = expected_decoded.pop_front();
			if (got.out_byte !== want.out_byte) begin
				errors++;
				$display("%0t: out_byte expected %02h got %02h",
					$time, want.out_byte, got.out_byte);
			end
			if (got.in_value !== want.in_value) begin
				errors++;
				$display("%0t: in_value expected %0b got %0b",
					$time, want.in_value, got.in_value);
			end
			if (got.pair_end !== want.pair_end) begin
				errors++;
				$display("%0t: pair_end expected %0b got %0b",
					$time, want.pair_end, got.pair_end);
			end
		endfunction

		function int waiting();
			return expected_decoded.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   idle_en;
	int   hold_req;
	int   quiet;
	decode_board board;

	fud_in_if  body ();
	fud_out_if dec ();

	form_urlencoded_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.body   (body),
		.dec    (dec)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int idle_gap();
		return idle_en ? $urandom_range(0, 16) : 0;
	endfunction

	// hex digit character with a random letter case
	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 10)
			return "0" + n;
		return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 10);
	endfunction

	// offer one body item and hold it until the transfer
	task automatic send_body(input logic op, input logic [7:0] b);
		int gap;
		gap = idle_gap();
		repeat (gap) @(negedge clk) body.valid <= 1'b0;
		@(negedge clk);
		body.valid     <= 1'b1;
		body.op        <= op;
		body.data_byte <= b;
		do @(posedge clk); while (!body.ready);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_body(OP_DATA, s[i]);
	endtask

	// random form content, mostly well-formed with some broken escapes
	task automatic send_random_form(input int n);
		int sent;
		int pick;
		logic [7:0] b;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
					: 8'("a" + $urandom_range(0, 25));
				send_body(OP_DATA, b);
				sent += 1;
			end else if (pick < 62) begin
				send_body(OP_DATA, CH_PERCENT);
				send_body(OP_DATA, hex_char(4'($urandom_range(0, 15))));
				send_body(OP_DATA, hex_char(4'($urandom_range(0, 15))));
				sent += 3;
			end else if (pick < 70) begin
				send_body(OP_DATA, CH_PLUS);
				sent += 1;
			end else if (pick < 78) begin
				send_body(OP_DATA, CH_EQUALS);
				sent += 1;
			end else if (pick < 86) begin
				send_body(OP_DATA, CH_AMP);
				sent += 1;
			end else if (pick < 91) begin
				send_body(OP_END, 8'($urandom_range(0, 255)));
				sent += 1;
			end else if (pick < 96) begin
				send_body(OP_DATA, CH_PERCENT);
				send_body(OP_DATA, 8'($urandom_range(0, 255)));
				sent += 2;
			end else begin
				send_body(OP_DATA, CH_PERCENT);
				send_body(OP_DATA, hex_char(4'($urandom_range(0, 15))));
				send_body(OP_DATA, 8'($urandom_range(0, 255)));
				sent += 3;
			end
		end
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int off;
		dec.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req > 0) begin
				off = hold_req;
				hold_req = 0;
			end else begin
				off = idle_gap();
			end
			if (off > 0) begin
				@(negedge clk) dec.ready <= 1'b0;
				repeat (off - 1) @(negedge clk);
			end
			@(negedge clk) dec.ready <= 1'b1;
			do @(posedge clk); while (!dec.valid);
		end
	end

	// transfer monitor and watchdog
	always @(posedge clk) begin
		out_item_t got;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (body.valid && body.ready) begin
				board.note_body(body.op, body.data_byte);
				moved = 1'b1;
			end
			if (dec.valid && dec.ready) begin
				got.out_byte = dec.out_byte;
				got.in_value = dec.in_value;
				got.pair_end = dec.pair_end;
				board.check_dec(got);
				moved = 1'b1;
			end
			if (moved) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= QUIET_LIMIT) begin
					$display("CHECKS FAILED");
					$finish;
				end
			end
		end
	end

	// main sequence
	initial begin
		board = new();
		board.clear_parse();
		clk            = 1'b0;
		arst_n         = 1'b0;
		idle_en        = 1'b1;
		hold_req       = 0;
		quiet          = 0;
		body.valid     = 1'b0;
		body.op        = OP_DATA;
		body.data_byte = 8'h00;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// name with plus, value with a lowercase hex escape, zero escape, equals, pair end
		send_text("a+=%4a%00=&");
		// ampersand in name, non-hex escapes handled again as plain
		send_text("&%Ff%G%4%");
		// end of body drops the pending escape, data ignored
		send_body(OP_END, 8'hFF);
		send_body(OP_DATA, 8'h00);
		send_body(OP_DATA, 8'hFF);
		// ampersand breaking an escape in a value still ends the pair
		send_text("=%7&");
		send_body(OP_END, 8'h00);

		// random phases with and without idling, one with a long receiver hold
		for (int ph = 0; ph < 4; ph++) begin
			idle_en = (ph != 1);
			if (ph == 2)
				hold_req = HOLD_CYCLES;
			send_random_form(470);
		end
		@(negedge clk) body.valid <= 1'b0;

		// drain
		while (board.waiting() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.waiting() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
